// ===== hw/rtl/ldpc_pkg.sv =====
// Shared types, sizes and codes for the LDPC min-sum decoder core.
// No dependencies; used by ldpc_min_sum_decoder_core.
package ldpc_pkg;

  localparam int NUM_BITS        = 512;
  localparam int NUM_CHECKS      = 256;
  localparam int NUM_EDGES       = 2048;
  localparam int ROW_WEIGHT      = 8;
  localparam int LAST_ROW_WEIGHT = 8;
  localparam int MAX_WEIGHT      = (ROW_WEIGHT > LAST_ROW_WEIGHT) ? ROW_WEIGHT : LAST_ROW_WEIGHT;

  localparam int BIT_W  = $clog2(NUM_BITS);
  localparam int CHK_W  = $clog2(NUM_CHECKS);
  localparam int EDGE_W = $clog2(NUM_EDGES);
  localparam int K_W    = $clog2(MAX_WEIGHT);

  localparam int MODE_W    = 3;
  localparam int INDEX_W   = 11;
  localparam int VALUE_W   = 11;
  localparam int ITER_W    = 9;
  localparam int MAXIT_W   = 8;
  localparam int LLR_W     = 7;
  localparam int MSG_W     = 8;
  localparam int POST_W    = 10;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [MODE_W-1:0] MODE_LOAD_COL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_ROW = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_BIT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DECODE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_BIT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LLR      = 1'd1;

  localparam logic [MAXIT_W-1:0] MAX_ITER_RST = 8'd20;
  localparam logic [LLR_W-1:0]   LLR_RST      = 7'd8;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic              result_kind;
    logic [ITER_W-1:0] iterations;
    logic              converged;
    logic              decoded_bit;
  } out_t;

  // last edge offset within a check row
  function automatic logic [K_W-1:0] last_k(input logic [CHK_W-1:0] row);
    return (row == CHK_W'(NUM_CHECKS - 1)) ? K_W'(LAST_ROW_WEIGHT - 1) : K_W'(ROW_WEIGHT - 1);
  endfunction

endpackage

// ===== hw/rtl/ldpc_min_sum_decoder_core.sv =====
// LDPC min-sum decoder core: matrix, bit and message memories plus sequencer.
// Depends on ldpc_pkg.
//
// Loads (edge column, row start, received bit) are written in S_IDLE, which
// stays ready for the next item. A bit read passes S_RDBIT, S_RDCAP and S_OUT
// before out_valid rises; S_OUT waits while an earlier result is still held.
// A decode first copies the hard bits to the prior store (S_CPY_RD, S_CPY_WR per
// bit) and, unless the iteration limit is zero, seeds every row edge's message;
// each iteration then sets the posteriors, runs the check rows (S_CHK_ROW, then
// S_CHK_RA/S_CHK_RB and S_CHK_EXT/S_PST_WR per edge), makes the hard decisions
// and, unless converged, updates the messages. Run time is set by the edge and
// bit memories, walked one entry at a time. One item is worked on at a time; the
// result register lets the next item in while a result waits.
module ldpc_min_sum_decoder_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ldpc_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ldpc_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [ldpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ldpc_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int BIT_W  = ldpc_pkg::BIT_W;
  localparam int CHK_W  = ldpc_pkg::CHK_W;
  localparam int EDGE_W = ldpc_pkg::EDGE_W;
  localparam int K_W    = ldpc_pkg::K_W;
  localparam int MSG_W  = ldpc_pkg::MSG_W;
  localparam int POST_W = ldpc_pkg::POST_W;
  localparam int ITER_W = ldpc_pkg::ITER_W;
  localparam int IDXC_W = ldpc_pkg::INDEX_W + 1;
  localparam int NST    = 19;

  typedef enum logic [NST-1:0] {
    S_IDLE     = NST'(1) << 0,
    S_RDBIT    = NST'(1) << 1,
    S_RDCAP    = NST'(1) << 2,
    S_OUT      = NST'(1) << 3,
    S_CPY_RD   = NST'(1) << 4,
    S_CPY_WR   = NST'(1) << 5,
    S_MSG_ROW  = NST'(1) << 6,
    S_MSG_EDGE = NST'(1) << 7,
    S_MSG_POST = NST'(1) << 8,
    S_MSG_WR   = NST'(1) << 9,
    S_INIT_RD  = NST'(1) << 10,
    S_INIT_WR  = NST'(1) << 11,
    S_CHK_ROW  = NST'(1) << 12,
    S_CHK_RA   = NST'(1) << 13,
    S_CHK_RB   = NST'(1) << 14,
    S_CHK_EXT  = NST'(1) << 15,
    S_PST_WR   = NST'(1) << 16,
    S_DEC_RD   = NST'(1) << 17,
    S_DEC_WR   = NST'(1) << 18
  } state_t;

  // memories
  logic [BIT_W-1:0]         col_mem   [ldpc_pkg::NUM_EDGES];
  logic [EDGE_W-1:0]        row_mem   [ldpc_pkg::NUM_CHECKS];
  logic                     hard_mem  [ldpc_pkg::NUM_BITS];
  logic                     prior_mem [ldpc_pkg::NUM_BITS];
  logic signed [MSG_W-1:0]  msg_mem   [ldpc_pkg::NUM_EDGES];
  logic signed [MSG_W-1:0]  extr_mem  [ldpc_pkg::NUM_EDGES];
  logic signed [POST_W-1:0] post_mem  [ldpc_pkg::NUM_BITS];

  logic [BIT_W-1:0]         rd_col_r;
  logic [EDGE_W-1:0]        rd_row_r;
  logic                     rd_hard_r;
  logic                     rd_prior_r;
  logic signed [MSG_W-1:0]  rd_msg_r;
  logic signed [MSG_W-1:0]  rd_extr_r;
  logic signed [POST_W-1:0] rd_post_r;

  state_t state_r, state_nxt;
  logic [ldpc_pkg::MAXIT_W-1:0] max_iter_r;
  logic [ldpc_pkg::LLR_W-1:0]   llr_r;
  logic [BIT_W-1:0]   b_r, b_nxt;
  logic [CHK_W-1:0]   r_r, r_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [ITER_W-1:0]  it_r, it_nxt;
  logic               upd_r, upd_nxt;
  logic               changed_r, changed_nxt;
  logic               oor_r, oor_nxt;
  logic [ldpc_pkg::INDEX_W-1:0] idx_r, idx_nxt;
  logic [MSG_W-1:0]   min1_r, min1_nxt, min2_r, min2_nxt;
  logic [K_W-1:0]     minidx_r, minidx_nxt;
  logic               parity_r, parity_nxt;
  logic signed [MSG_W-1:0] ext_r, ext_nxt;
  logic [BIT_W-1:0]   ccol_r [ldpc_pkg::MAX_WEIGHT];
  logic [ldpc_pkg::MAX_WEIGHT-1:0] sign_r;
  ldpc_pkg::out_t     res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  ldpc_pkg::out_t     out_data_r, out_data_nxt;

  logic [EDGE_W-1:0]  edge_idx;
  logic [K_W-1:0]     k_last;
  logic [BIT_W-1:0]   post_ra, prior_ra, hard_ra;
  logic               hard_we, hard_wd;
  logic [BIT_W-1:0]   hard_wa;
  logic               post_we;
  logic [BIT_W-1:0]   post_wa;
  logic signed [POST_W-1:0] post_wd;
  logic               prior_we, msg_we, extr_we;
  logic signed [MSG_W-1:0]  msg_wd;
  logic               in_acc;
  logic signed [MSG_W-1:0]  prior_msg, msg_upd;
  logic signed [POST_W-1:0] prior_post, post_sum;
  logic [MSG_W-1:0]   cur_mag, sel_mag;

  function automatic logic signed [POST_W-1:0] sat_post(input logic signed [POST_W:0] v);
    logic signed [POST_W:0] hi;
    logic signed [POST_W:0] lo;
    hi = (POST_W+1)'((2 ** (POST_W - 1)) - 1);
    lo = -(POST_W+1)'(2 ** (POST_W - 1));
    if (v > hi) return hi[POST_W-1:0];
    if (v < lo) return lo[POST_W-1:0];
    return v[POST_W-1:0];
  endfunction

  function automatic logic signed [MSG_W-1:0] sat_msg(input logic signed [POST_W:0] v);
    logic signed [POST_W:0] hi;
    logic signed [POST_W:0] lo;
    hi = (POST_W+1)'((2 ** (MSG_W - 1)) - 1);
    lo = -hi;
    if (v > hi) return hi[MSG_W-1:0];
    if (v < lo) return lo[MSG_W-1:0];
    return v[MSG_W-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign edge_idx = rd_row_r + EDGE_W'(k_r);
  assign k_last   = ldpc_pkg::last_k(r_r);

  // prior is +llr for a zero bit, -llr for a one bit
  assign prior_msg  = rd_prior_r ? -$signed({1'b0, llr_r}) : $signed({1'b0, llr_r});
  assign prior_post = POST_W'(prior_msg);
  assign msg_upd    = sat_msg((POST_W+1)'(rd_post_r) - (POST_W+1)'(rd_extr_r));
  assign post_sum   = sat_post((POST_W+1)'(rd_post_r) + (POST_W+1)'(ext_r));
  assign cur_mag    = rd_msg_r[MSG_W-1] ? MSG_W'(-rd_msg_r) : MSG_W'(rd_msg_r);
  assign sel_mag    = (k_r == minidx_r) ? min2_r : min1_r;

  always_comb begin
    post_ra  = b_r;
    prior_ra = b_r;
    hard_ra  = b_r;
    case (state_r)
      S_MSG_POST: begin
        post_ra  = rd_col_r;
        prior_ra = rd_col_r;
      end
      S_CHK_EXT: post_ra = ccol_r[k_r];
      S_RDBIT:   hard_ra = idx_r[BIT_W-1:0];
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    b_nxt         = b_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    it_nxt        = it_r;
    upd_nxt       = upd_r;
    changed_nxt   = changed_r;
    oor_nxt       = oor_r;
    idx_nxt       = idx_r;
    min1_nxt      = min1_r;
    min2_nxt      = min2_r;
    minidx_nxt    = minidx_r;
    parity_nxt    = parity_r;
    ext_nxt       = ext_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    hard_we  = 1'b0;
    hard_wa  = b_r;
    hard_wd  = 1'b0;
    post_we  = 1'b0;
    post_wa  = b_r;
    post_wd  = prior_post;
    prior_we = 1'b0;
    msg_we   = 1'b0;
    msg_wd   = upd_r ? msg_upd : prior_msg;
    extr_we  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.mode)
            ldpc_pkg::MODE_LOAD_BIT: begin
              hard_we = ({1'b0, in_data.index} < IDXC_W'(ldpc_pkg::NUM_BITS));
              hard_wa = in_data.index[BIT_W-1:0];
              hard_wd = in_data.value[0];
            end
            ldpc_pkg::MODE_DECODE: begin
              b_nxt     = '0;
              it_nxt    = ITER_W'(1);
              state_nxt = S_CPY_RD;
            end
            ldpc_pkg::MODE_READ_BIT: begin
              idx_nxt   = in_data.index;
              oor_nxt   = !({1'b0, in_data.index} < IDXC_W'(ldpc_pkg::NUM_BITS));
              state_nxt = S_RDBIT;
            end
            default: ;
          endcase
        end
      end
      S_RDBIT: state_nxt = S_RDCAP;
      S_RDCAP: begin
        res_nxt             = '0;
        res_nxt.result_kind = 1'b1;
        res_nxt.decoded_bit = oor_r ? 1'b0 : rd_hard_r;
        state_nxt           = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      S_CPY_RD: state_nxt = S_CPY_WR;
      S_CPY_WR: begin
        prior_we = 1'b1;
        if (b_r == BIT_W'(ldpc_pkg::NUM_BITS - 1)) begin
          b_nxt = '0;
          if (max_iter_r == '0) begin
            res_nxt            = '0;
            res_nxt.iterations = ITER_W'(1);
            state_nxt          = S_OUT;
          end else begin
            upd_nxt   = 1'b0;
            r_nxt     = '0;
            k_nxt     = '0;
            state_nxt = S_MSG_ROW;
          end
        end else begin
          b_nxt     = b_r + BIT_W'(1);
          state_nxt = S_CPY_RD;
        end
      end
      S_MSG_ROW:  state_nxt = S_MSG_EDGE;
      S_MSG_EDGE: state_nxt = S_MSG_POST;
      S_MSG_POST: state_nxt = S_MSG_WR;
      S_MSG_WR: begin
        msg_we = 1'b1;
        if (k_r == k_last) begin
          k_nxt = '0;
          if (r_r == CHK_W'(ldpc_pkg::NUM_CHECKS - 1)) begin
            r_nxt = '0;
            b_nxt = '0;
            if (!upd_r) begin
              state_nxt = S_INIT_RD;
            end else if (it_r >= ITER_W'(max_iter_r)) begin
              res_nxt            = '0;
              res_nxt.iterations = it_r + ITER_W'(1);
              state_nxt          = S_OUT;
            end else begin
              it_nxt    = it_r + ITER_W'(1);
              state_nxt = S_INIT_RD;
            end
          end else begin
            r_nxt     = r_r + CHK_W'(1);
            state_nxt = S_MSG_ROW;
          end
        end else begin
          k_nxt     = k_r + K_W'(1);
          state_nxt = S_MSG_EDGE;
        end
      end
      S_INIT_RD: state_nxt = S_INIT_WR;
      S_INIT_WR: begin
        post_we = 1'b1;
        if (b_r == BIT_W'(ldpc_pkg::NUM_BITS - 1)) begin
          b_nxt     = '0;
          r_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_CHK_ROW;
        end else begin
          b_nxt     = b_r + BIT_W'(1);
          state_nxt = S_INIT_RD;
        end
      end
      S_CHK_ROW: begin
        min1_nxt   = '1;
        min2_nxt   = '1;
        minidx_nxt = '0;
        parity_nxt = 1'b0;
        k_nxt      = '0;
        state_nxt  = S_CHK_RA;
      end
      S_CHK_RA: state_nxt = S_CHK_RB;
      S_CHK_RB: begin
        parity_nxt = parity_r ^ rd_msg_r[MSG_W-1];
        if (cur_mag < min1_r) begin
          min2_nxt   = min1_r;
          min1_nxt   = cur_mag;
          minidx_nxt = k_r;
        end else if (cur_mag < min2_r) begin
          min2_nxt = cur_mag;
        end
        if (k_r == k_last) begin
          k_nxt     = '0;
          state_nxt = S_CHK_EXT;
        end else begin
          k_nxt     = k_r + K_W'(1);
          state_nxt = S_CHK_RA;
        end
      end
      S_CHK_EXT: begin
        // sign of the other edges is total parity with this edge's sign removed
        ext_nxt   = (parity_r ^ sign_r[k_r]) ? -$signed(sel_mag) : $signed(sel_mag);
        extr_we   = 1'b1;
        state_nxt = S_PST_WR;
      end
      S_PST_WR: begin
        post_we = 1'b1;
        post_wa = ccol_r[k_r];
        post_wd = post_sum;
        if (k_r == k_last) begin
          k_nxt = '0;
          if (r_r == CHK_W'(ldpc_pkg::NUM_CHECKS - 1)) begin
            r_nxt       = '0;
            b_nxt       = '0;
            changed_nxt = 1'b0;
            state_nxt   = S_DEC_RD;
          end else begin
            r_nxt     = r_r + CHK_W'(1);
            state_nxt = S_CHK_ROW;
          end
        end else begin
          k_nxt     = k_r + K_W'(1);
          state_nxt = S_CHK_EXT;
        end
      end
      S_DEC_RD: state_nxt = S_DEC_WR;
      S_DEC_WR: begin
        // zero posterior keeps the old decision
        if (rd_post_r != '0) begin
          hard_we = 1'b1;
          hard_wd = rd_post_r[POST_W-1];
          if (rd_post_r[POST_W-1] != rd_hard_r) changed_nxt = 1'b1;
        end
        if (b_r == BIT_W'(ldpc_pkg::NUM_BITS - 1)) begin
          b_nxt = '0;
          if (!changed_nxt) begin
            res_nxt            = '0;
            res_nxt.iterations = it_r;
            res_nxt.converged  = 1'b1;
            state_nxt          = S_OUT;
          end else begin
            upd_nxt   = 1'b1;
            r_nxt     = '0;
            k_nxt     = '0;
            state_nxt = S_MSG_ROW;
          end
        end else begin
          b_nxt     = b_r + BIT_W'(1);
          state_nxt = S_DEC_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      max_iter_r  <= ldpc_pkg::MAX_ITER_RST;
      llr_r       <= ldpc_pkg::LLR_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ldpc_pkg::CFG_MAX_ITER: max_iter_r <= cfg_wdata[ldpc_pkg::MAXIT_W-1:0];
          ldpc_pkg::CFG_LLR:      llr_r      <= cfg_wdata[ldpc_pkg::LLR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    b_r        <= b_nxt;
    r_r        <= r_nxt;
    k_r        <= k_nxt;
    it_r       <= it_nxt;
    upd_r      <= upd_nxt;
    changed_r  <= changed_nxt;
    oor_r      <= oor_nxt;
    idx_r      <= idx_nxt;
    min1_r     <= min1_nxt;
    min2_r     <= min2_nxt;
    minidx_r   <= minidx_nxt;
    parity_r   <= parity_nxt;
    ext_r      <= ext_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == S_CHK_RB) begin
      ccol_r[k_r] <= rd_col_r;
      sign_r[k_r] <= rd_msg_r[MSG_W-1];
    end
  end

  // memory ports: one write, one registered read each
  always_ff @(posedge clk) begin
    if (in_acc && in_data.mode == ldpc_pkg::MODE_LOAD_COL &&
        ({1'b0, in_data.index} < IDXC_W'(ldpc_pkg::NUM_EDGES)))
      col_mem[in_data.index[EDGE_W-1:0]] <= BIT_W'(in_data.value);
    rd_col_r <= col_mem[edge_idx];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.mode == ldpc_pkg::MODE_LOAD_ROW &&
        ({1'b0, in_data.index} < IDXC_W'(ldpc_pkg::NUM_CHECKS)))
      row_mem[in_data.index[CHK_W-1:0]] <= EDGE_W'(in_data.value);
    rd_row_r <= row_mem[r_r];
  end

  always_ff @(posedge clk) begin
    if (hard_we) hard_mem[hard_wa] <= hard_wd;
    rd_hard_r <= hard_mem[hard_ra];
  end

  always_ff @(posedge clk) begin
    if (prior_we) prior_mem[b_r] <= rd_hard_r;
    rd_prior_r <= prior_mem[prior_ra];
  end

  always_ff @(posedge clk) begin
    if (msg_we) msg_mem[edge_idx] <= msg_wd;
    rd_msg_r <= msg_mem[edge_idx];
  end

  always_ff @(posedge clk) begin
    if (extr_we) extr_mem[edge_idx] <= ext_nxt;
    rd_extr_r <= extr_mem[edge_idx];
  end

  always_ff @(posedge clk) begin
    if (post_we) post_mem[post_wa] <= post_wd;
    rd_post_r <= post_mem[post_ra];
  end

endmodule
